[sv/dqsv_pkg.sv]
package dqsv_pkg;

  // field widths
  localparam int ANGLE_BITS     = 16;
  localparam int VOLTAGE_BITS   = 16;
  localparam int DUTY_FRAC_BITS = 16;
  localparam int DUTY_W         = DUTY_FRAC_BITS + 1;

  // rotation datapath
  localparam int GUARD_BITS  = 48 - VOLTAGE_BITS;
  localparam int CORDIC_W    = 50;
  localparam int RES_W       = 32;
  localparam int ROT_STEPS   = 24;
  localparam int SCALE_SHIFT = 18;
  localparam int XS_W        = CORDIC_W - SCALE_SHIFT;

  // magnitude and normalize
  localparam int SQ_W       = 64;
  localparam int ROOT_STEPS = 32;
  localparam int LK_W       = 30;
  localparam int DEN_W      = 32;
  localparam int MAG_W      = 32;
  localparam int REM_W      = 33;
  localparam int QUO_W      = 31;
  localparam int UNIT_W     = 32;

  // phase projection and duty math
  localparam int PH_W       = 36;
  localparam int N3_W       = 34;
  localparam int N3_LO_W    = 17;
  localparam int N3_HI_W    = N3_W - N3_LO_W;
  localparam int DIV3_W     = 34;
  localparam int DIV3_SHIFT = 35;
  localparam int Q3_W       = 33;
  localparam int DQ_W       = 32;

  localparam logic [LK_W-1:0]   GAIN_OVER_SQRT3_Q30 = 30'd1020868070;
  localparam logic [29:0]       HALF_SQRT3_Q30      = 30'd929887697;
  localparam logic [DIV3_W-1:0] DIV3_MUL            = 34'd11453246123;
  localparam logic [DQ_W-1:0]   ONE_Q31             = 32'h8000_0000;

  // quadrant codes of the angle
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic        [VOLTAGE_BITS-1:0] bus_voltage;
    logic signed [VOLTAGE_BITS-1:0] d_voltage;
    logic signed [VOLTAGE_BITS-1:0] q_voltage;
    logic        [ANGLE_BITS-1:0]   electrical_angle;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic              bus_fault;
  } out_t;

  // arctangent steps in 32-bit turns
  function automatic logic [29:0] turn_step(input int idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'h20000000;
      1:  v = 30'h12E4051E;
      2:  v = 30'h09FB385B;
      3:  v = 30'h051111D4;
      4:  v = 30'h028B0D43;
      5:  v = 30'h0145D7E1;
      6:  v = 30'h00A2F61E;
      7:  v = 30'h00517C55;
      8:  v = 30'h0028BE53;
      9:  v = 30'h00145F2F;
      10: v = 30'h000A2F98;
      11: v = 30'h000517CC;
      12: v = 30'h00028BE6;
      13: v = 30'h000145F3;
      14: v = 30'h0000A2FA;
      15: v = 30'h0000517D;
      16: v = 30'h000028BE;
      17: v = 30'h0000145F;
      18: v = 30'h00000A30;
      19: v = 30'h00000518;
      20: v = 30'h0000028C;
      21: v = 30'h00000146;
      22: v = 30'h000000A3;
      23: v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

[sv/dqsv_cordic.sv]
module dqsv_cordic #(
  parameter int SIDE_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [dqsv_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [dqsv_pkg::CORDIC_W-1:0] y_in,
  input  logic signed [dqsv_pkg::RES_W-1:0]    r_in,
  input  logic        [SIDE_W-1:0]             side_in,
  output logic                                 out_valid,
  output logic signed [dqsv_pkg::CORDIC_W-1:0] x_out,
  output logic signed [dqsv_pkg::CORDIC_W-1:0] y_out,
  output logic        [SIDE_W-1:0]             side_out
);
  import dqsv_pkg::*;

  logic signed [CORDIC_W-1:0] x_r    [ROT_STEPS];
  logic signed [CORDIC_W-1:0] y_r    [ROT_STEPS];
  logic signed [RES_W-1:0]    r_r    [ROT_STEPS];
  logic        [SIDE_W-1:0]   side_r [ROT_STEPS];
  logic                       v_r    [ROT_STEPS];

  // one micro-rotation per stage
  for (genvar i = 0; i < ROT_STEPS; i++) begin : g_stage
    logic signed [CORDIC_W-1:0] xp, yp;
    logic signed [RES_W-1:0]    rp;
    logic        [SIDE_W-1:0]   sp;
    logic                       vp;
    if (i == 0) begin : g_first
      assign xp = x_in;
      assign yp = y_in;
      assign rp = r_in;
      assign sp = side_in;
      assign vp = in_valid;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign rp = r_r[i-1];
      assign sp = side_r[i-1];
      assign vp = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= sp;
        if (!rp[RES_W-1]) begin
          x_r[i] <= xp - (yp >>> i);
          y_r[i] <= yp + (xp >>> i);
          r_r[i] <= rp - $signed({2'b00, turn_step(i)});
        end else begin
          x_r[i] <= xp + (yp >>> i);
          y_r[i] <= yp - (xp >>> i);
          r_r[i] <= rp + $signed({2'b00, turn_step(i)});
        end
      end
    end
  end

  assign out_valid = v_r[ROT_STEPS-1];
  assign x_out     = x_r[ROT_STEPS-1];
  assign y_out     = y_r[ROT_STEPS-1];
  assign side_out  = side_r[ROT_STEPS-1];

endmodule

[sv/dqsv_divider.sv]
module dqsv_divider #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [dqsv_pkg::DEN_W-1:0]    den,
  input  logic [dqsv_pkg::MAG_W-1:0]    mag_x,
  input  logic [dqsv_pkg::MAG_W-1:0]    mag_y,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          out_valid,
  output logic [dqsv_pkg::QUO_W-1:0]    quo_x,
  output logic [dqsv_pkg::QUO_W-1:0]    quo_y,
  output logic [SIDE_W-1:0]             side_out
);
  import dqsv_pkg::*;

  logic [REM_W-1:0]  rx_r   [QUO_W];
  logic [REM_W-1:0]  ry_r   [QUO_W];
  logic [QUO_W-1:0]  qx_r   [QUO_W];
  logic [QUO_W-1:0]  qy_r   [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];
  logic              v_r    [QUO_W];

  // restoring division, one quotient bit per stage for both lanes
  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [REM_W-1:0]  rxp, ryp, rx2, ry2, dext;
    logic [QUO_W-1:0]  qxp, qyp;
    logic [DEN_W-1:0]  dp;
    logic [SIDE_W-1:0] sp;
    logic              vp;
    if (j == 0) begin : g_first
      assign rx2 = REM_W'(mag_x);
      assign ry2 = REM_W'(mag_y);
      assign qxp = '0;
      assign qyp = '0;
      assign dp  = den;
      assign sp  = side_in;
      assign vp  = in_valid;
      assign rxp = '0;
      assign ryp = '0;
    end else begin : g_next
      assign rxp = rx_r[j-1];
      assign ryp = ry_r[j-1];
      assign rx2 = rxp << 1;
      assign ry2 = ryp << 1;
      assign qxp = qx_r[j-1];
      assign qyp = qy_r[j-1];
      assign dp  = den_r[j-1];
      assign sp  = side_r[j-1];
      assign vp  = v_r[j-1];
    end
    assign dext = REM_W'(dp);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j]  <= dp;
        side_r[j] <= sp;
        if (rx2 >= dext) begin
          rx_r[j] <= rx2 - dext;
          qx_r[j] <= {qxp[QUO_W-2:0], 1'b1};
        end else begin
          rx_r[j] <= rx2;
          qx_r[j] <= {qxp[QUO_W-2:0], 1'b0};
        end
        if (ry2 >= dext) begin
          ry_r[j] <= ry2 - dext;
          qy_r[j] <= {qyp[QUO_W-2:0], 1'b1};
        end else begin
          ry_r[j] <= ry2;
          qy_r[j] <= {qyp[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[QUO_W-1];
  assign quo_x     = qx_r[QUO_W-1];
  assign quo_y     = qy_r[QUO_W-1];
  assign side_out  = side_r[QUO_W-1];

endmodule

[sv/dq_to_svpwm_duty.sv]
// Space-vector PWM duty generator: each request (bus voltage, d/q command,
// electrical angle) gives one result with three centred duties in Q1.16 and
// a bus fault flag. The block is a pipeline (24 CORDIC stages,
// a 32-stage square root, a 31-stage dual divider and the projection and
// duty stages around them), so it takes one request every clock, except
// while out_ready holds results back. A two-entry output buffer keeps
// in_ready a plain register. min_bus_level is written through the cfg
// port (reset 1) and should only change while no request is in flight.
module dq_to_svpwm_duty (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  dqsv_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output dqsv_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dqsv_pkg::VOLTAGE_BITS-1:0]    cfg_data
);
  import dqsv_pkg::*;

  localparam int VB = VOLTAGE_BITS;
  localparam int AB = ANGLE_BITS;
  localparam int DF = DUTY_FRAC_BITS;
  localparam logic [DUTY_W-1:0] HALF_DUTY = DUTY_W'(1) << (DF - 1);
  localparam logic [DQ_W-1:0]   ROUND_ADD = DQ_W'(1) << (30 - DF);

  logic en;
  logic skid_full_r;

  assign en        = !skid_full_r;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // configuration register
  logic [VB-1:0] min_bus_level_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bus_level_r <= VB'(1);
    end else if (cfg_valid) begin
      min_bus_level_r <= cfg_data;
    end
  end

  // input stage: fault compare and quarter-turn pre-rotation
  logic signed [CORDIC_W-1:0] x0, y0, s0_x_r, s0_y_r;
  logic signed [RES_W-1:0]    s0_res_r;
  logic        [VB-1:0]       s0_bus_r;
  logic                       s0_fault_r, s0_v_r;
  logic        [1:0]          quad;

  assign quad = in_data.electrical_angle[AB-1:AB-2];
  assign x0   = CORDIC_W'(in_data.d_voltage) <<< GUARD_BITS;
  assign y0   = CORDIC_W'(in_data.q_voltage) <<< GUARD_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_bus_r   <= in_data.bus_voltage;
      s0_fault_r <= in_data.bus_voltage <= min_bus_level_r;
      s0_res_r   <= $signed({2'b00, in_data.electrical_angle[AB-3:0], (RES_W-AB)'(0)});
      case (quad)
        QUAD_1: begin s0_x_r <= -y0; s0_y_r <= x0;  end
        QUAD_2: begin s0_x_r <= -x0; s0_y_r <= -y0; end
        QUAD_3: begin s0_x_r <= y0;  s0_y_r <= -x0; end
        default: begin s0_x_r <= x0; s0_y_r <= y0;  end
      endcase
    end
  end

  // inverse park rotation
  logic                       c_v;
  logic signed [CORDIC_W-1:0] c_x, c_y;
  logic        [VB:0]         c_side;

  dqsv_cordic #(.SIDE_W(VB + 1)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s0_v_r),
    .x_in     (s0_x_r),
    .y_in     (s0_y_r),
    .r_in     (s0_res_r),
    .side_in  ({s0_fault_r, s0_bus_r}),
    .out_valid(c_v),
    .x_out    (c_x),
    .y_out    (c_y),
    .side_out (c_side)
  );

  // squares and scaled radius
  logic signed [XS_W-1:0]    xs, ys, m_xs_r, m_ys_r, a_xs_r, a_ys_r;
  logic signed [SQ_W-1:0]    m_sqx_r, m_sqy_r;
  logic        [VB+LK_W-1:0] lk_prod;
  logic        [LK_W-1:0]    m_lk_r, a_lk_r;
  logic                      m_fault_r, a_fault_r, m_v_r, a_v_r;
  logic        [SQ_W-1:0]    a_sum_r;

  assign xs      = c_x[CORDIC_W-1:SCALE_SHIFT];
  assign ys      = c_y[CORDIC_W-1:SCALE_SHIFT];
  assign lk_prod = c_side[VB-1:0] * GAIN_OVER_SQRT3_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      a_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= c_v;
      a_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_xs_r    <= xs;
      m_ys_r    <= ys;
      m_sqx_r   <= xs * xs;
      m_sqy_r   <= ys * ys;
      m_lk_r    <= lk_prod[VB+LK_W-1:VB];
      m_fault_r <= c_side[VB];
      a_xs_r    <= m_xs_r;
      a_ys_r    <= m_ys_r;
      a_lk_r    <= m_lk_r;
      a_fault_r <= m_fault_r;
      a_sum_r   <= $unsigned(m_sqx_r) + $unsigned(m_sqy_r);
    end
  end

  // floor square root, one result bit per stage
  localparam int RSIDE_W = 2 * XS_W + LK_W + 1;
  logic [SQ_W-1:0]    rt_n_r    [ROOT_STEPS];
  logic [SQ_W-1:0]    rt_r_r    [ROOT_STEPS];
  logic [RSIDE_W-1:0] rt_side_r [ROOT_STEPS];
  logic               rt_v_r    [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic [SQ_W-1:0]    np, rp, trial;
    logic [RSIDE_W-1:0] sp;
    logic               vp;
    if (k == 0) begin : g_first
      assign np = a_sum_r;
      assign rp = '0;
      assign sp = {a_fault_r, a_lk_r, a_xs_r, a_ys_r};
      assign vp = a_v_r;
    end else begin : g_next
      assign np = rt_n_r[k-1];
      assign rp = rt_r_r[k-1];
      assign sp = rt_side_r[k-1];
      assign vp = rt_v_r[k-1];
    end
    assign trial = rp + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[k] <= 1'b0;
      end else if (en) begin
        rt_v_r[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_side_r[k] <= sp;
        if (np >= trial) begin
          rt_n_r[k] <= np - trial;
          rt_r_r[k] <= (rp >> 1) + BIT;
        end else begin
          rt_n_r[k] <= np;
          rt_r_r[k] <= rp >> 1;
        end
      end
    end
  end

  // denominator pick and magnitudes
  logic [RSIDE_W-1:0]     rt_side;
  logic [DEN_W-1:0]       root_val, lk_ext;
  logic signed [XS_W-1:0] r_xs, r_ys;
  logic [DEN_W-1:0]       dn_den_r;
  logic [MAG_W-1:0]       dn_mx_r, dn_my_r;
  logic [3:0]             dn_side_r;
  logic                   dn_v_r;

  assign rt_side  = rt_side_r[ROOT_STEPS-1];
  assign root_val = rt_r_r[ROOT_STEPS-1][DEN_W-1:0];
  assign lk_ext   = DEN_W'(rt_side[2*XS_W +: LK_W]);
  assign r_xs     = rt_side[XS_W +: XS_W];
  assign r_ys     = rt_side[0 +: XS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_v_r <= 1'b0;
    end else if (en) begin
      dn_v_r <= rt_v_r[ROOT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_den_r  <= (root_val > lk_ext) ? root_val : lk_ext;
      dn_mx_r   <= r_xs[XS_W-1] ? MAG_W'(-r_xs) : MAG_W'(r_xs);
      dn_my_r   <= r_ys[XS_W-1] ? MAG_W'(-r_ys) : MAG_W'(r_ys);
      // fault, zero denominator, sign x, sign y
      dn_side_r <= {rt_side[RSIDE_W-1], (root_val == '0) && (lk_ext == '0),
                    r_xs[XS_W-1], r_ys[XS_W-1]};
    end
  end

  // normalize to unit length
  logic             dv_v;
  logic [QUO_W-1:0] dv_qx, dv_qy;
  logic [3:0]       dv_side;

  dqsv_divider #(.SIDE_W(4)) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (dn_v_r),
    .den      (dn_den_r),
    .mag_x    (dn_mx_r),
    .mag_y    (dn_my_r),
    .side_in  (dn_side_r),
    .out_valid(dv_v),
    .quo_x    (dv_qx),
    .quo_y    (dv_qy),
    .side_out (dv_side)
  );

  // signed unit vector
  logic signed [UNIT_W-1:0] ux, uy, n_x_r, n_y_r;
  logic                     n_fault_r, n_v_r;

  assign ux = dv_side[1] ? -$signed(UNIT_W'(dv_qx)) : $signed(UNIT_W'(dv_qx));
  assign uy = dv_side[0] ? -$signed(UNIT_W'(dv_qy)) : $signed(UNIT_W'(dv_qy));

  always_ff @(posedge clk) begin
    if (en) begin
      n_x_r     <= dv_side[2] ? '0 : ux;
      n_y_r     <= dv_side[2] ? '0 : uy;
      n_fault_r <= dv_side[3];
    end
  end

  // sqrt3/2 times y
  logic signed [UNIT_W+30:0] t_prod_r;
  logic signed [UNIT_W-1:0]  t_x_r;
  logic                      t_fault_r, t_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t_prod_r  <= $signed({1'b0, HALF_SQRT3_Q30}) * n_y_r;
      t_x_r     <= n_x_r;
      t_fault_r <= n_fault_r;
    end
  end

  // phase projections
  logic signed [PH_W-1:0] t_val, x_ext;
  logic signed [PH_W-1:0] p_a_r, p_b_r, p_c_r;
  logic                   p_fault_r, p_v_r;

  assign t_val = PH_W'(t_prod_r >>> 29);
  assign x_ext = PH_W'(t_x_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p_a_r     <= x_ext <<< 1;
      p_b_r     <= t_val - x_ext;
      p_c_r     <= -x_ext - t_val;
      p_fault_r <= t_fault_r;
    end
  end

  // minimum phase
  logic signed [PH_W-1:0] min_ab;
  logic signed [PH_W-1:0] m2_a_r, m2_b_r, m2_c_r, m2_min_r;
  logic                   m2_fault_r, m2_v_r;

  assign min_ab = (p_b_r < p_a_r) ? p_b_r : p_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_a_r     <= p_a_r;
      m2_b_r     <= p_b_r;
      m2_c_r     <= p_c_r;
      m2_min_r   <= (p_c_r < min_ab) ? p_c_r : min_ab;
      m2_fault_r <= p_fault_r;
    end
  end

  // twice the distance above the minimum
  logic [PH_W-1:0] da, db, dc;
  logic [N3_W-1:0] e_a_r, e_b_r, e_c_r;
  logic            e_fault_r, e_v_r;

  assign da = $unsigned(m2_a_r - m2_min_r);
  assign db = $unsigned(m2_b_r - m2_min_r);
  assign dc = $unsigned(m2_c_r - m2_min_r);

  always_ff @(posedge clk) begin
    if (en) begin
      e_a_r     <= {da[N3_W-2:0], 1'b0};
      e_b_r     <= {db[N3_W-2:0], 1'b0};
      e_c_r     <= {dc[N3_W-2:0], 1'b0};
      e_fault_r <= m2_fault_r;
    end
  end

  // divide by three: reciprocal multiply in two partial products
  localparam int PP_W = N3_HI_W + DIV3_W;
  logic [PP_W-1:0] k_ha_r, k_la_r, k_hb_r, k_lb_r, k_hc_r, k_lc_r;
  logic            k_fault_r, k_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      k_ha_r    <= e_a_r[N3_W-1:N3_LO_W] * DIV3_MUL;
      k_la_r    <= e_a_r[N3_LO_W-1:0] * DIV3_MUL;
      k_hb_r    <= e_b_r[N3_W-1:N3_LO_W] * DIV3_MUL;
      k_lb_r    <= e_b_r[N3_LO_W-1:0] * DIV3_MUL;
      k_hc_r    <= e_c_r[N3_W-1:N3_LO_W] * DIV3_MUL;
      k_lc_r    <= e_c_r[N3_LO_W-1:0] * DIV3_MUL;
      k_fault_r <= e_fault_r;
    end
  end

  localparam int FP_W = PP_W + N3_LO_W;
  logic [FP_W-1:0] fa, fb, fc;
  logic [Q3_W-1:0] q_a_r, q_b_r, q_c_r;
  logic            q_fault_r, q_v_r;

  assign fa = {k_ha_r, N3_LO_W'(0)} + FP_W'(k_la_r);
  assign fb = {k_hb_r, N3_LO_W'(0)} + FP_W'(k_lb_r);
  assign fc = {k_hc_r, N3_LO_W'(0)} + FP_W'(k_lc_r);

  always_ff @(posedge clk) begin
    if (en) begin
      q_a_r     <= fa[DIV3_SHIFT +: Q3_W];
      q_b_r     <= fb[DIV3_SHIFT +: Q3_W];
      q_c_r     <= fc[DIV3_SHIFT +: Q3_W];
      q_fault_r <= k_fault_r;
    end
  end

  // active span, clamped to one
  logic [Q3_W-1:0] max_ab, max_abc;
  logic [DQ_W-1:0] s_span_r;
  logic [Q3_W-1:0] s_a_r, s_b_r, s_c_r;
  logic            s_fault_r, s_v_r;

  assign max_ab  = (q_b_r > q_a_r) ? q_b_r : q_a_r;
  assign max_abc = (q_c_r > max_ab) ? q_c_r : max_ab;

  always_ff @(posedge clk) begin
    if (en) begin
      s_span_r  <= (max_abc > Q3_W'(ONE_Q31)) ? ONE_Q31 : DQ_W'(max_abc);
      s_a_r     <= q_a_r;
      s_b_r     <= q_b_r;
      s_c_r     <= q_c_r;
      s_fault_r <= q_fault_r;
    end
  end

  // half of the zero-vector time
  logic [DQ_W-1:0] zero_time;
  logic [DQ_W-1:0] o_off_r;
  logic [Q3_W-1:0] o_a_r, o_b_r, o_c_r;
  logic            o_fault_r, o_v_r;

  assign zero_time = ONE_Q31 - s_span_r;

  always_ff @(posedge clk) begin
    if (en) begin
      o_off_r   <= zero_time >> 1;
      o_a_r     <= s_a_r;
      o_b_r     <= s_b_r;
      o_c_r     <= s_c_r;
      o_fault_r <= s_fault_r;
    end
  end

  // duty sum, clamped to one
  localparam int DS_W = Q3_W + 1;
  logic [DS_W-1:0] sa, sb, sc;
  logic [DQ_W-1:0] d_a_r, d_b_r, d_c_r;
  logic            d_fault_r, d_v_r;

  assign sa = DS_W'(o_a_r) + DS_W'(o_off_r);
  assign sb = DS_W'(o_b_r) + DS_W'(o_off_r);
  assign sc = DS_W'(o_c_r) + DS_W'(o_off_r);

  always_ff @(posedge clk) begin
    if (en) begin
      d_a_r     <= (sa > DS_W'(ONE_Q31)) ? ONE_Q31 : DQ_W'(sa);
      d_b_r     <= (sb > DS_W'(ONE_Q31)) ? ONE_Q31 : DQ_W'(sb);
      d_c_r     <= (sc > DS_W'(ONE_Q31)) ? ONE_Q31 : DQ_W'(sc);
      d_fault_r <= o_fault_r;
    end
  end

  // round to output precision, fault override
  logic [DQ_W-1:0] ra, rb, rc;
  out_t            f_res, f_data_r;
  logic            f_v_r;

  assign ra = d_a_r + ROUND_ADD;
  assign rb = d_b_r + ROUND_ADD;
  assign rc = d_c_r + ROUND_ADD;

  always_comb begin
    f_res.bus_fault = d_fault_r;
    if (d_fault_r) begin
      f_res.duty_a = HALF_DUTY;
      f_res.duty_b = HALF_DUTY;
      f_res.duty_c = HALF_DUTY;
    end else begin
      f_res.duty_a = ra[31:31-DF];
      f_res.duty_b = rb[31:31-DF];
      f_res.duty_c = rc[31:31-DF];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_data_r <= f_res;
    end
  end

  // valid bits of the tail stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r  <= 1'b0;
      t_v_r  <= 1'b0;
      p_v_r  <= 1'b0;
      m2_v_r <= 1'b0;
      e_v_r  <= 1'b0;
      k_v_r  <= 1'b0;
      q_v_r  <= 1'b0;
      s_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
      f_v_r  <= 1'b0;
    end else if (en) begin
      n_v_r  <= dv_v;
      t_v_r  <= n_v_r;
      p_v_r  <= t_v_r;
      m2_v_r <= p_v_r;
      e_v_r  <= m2_v_r;
      k_v_r  <= e_v_r;
      q_v_r  <= k_v_r;
      s_v_r  <= q_v_r;
      o_v_r  <= s_v_r;
      d_v_r  <= o_v_r;
      f_v_r  <= d_v_r;
    end
  end

  // output register with skid entry
  logic out_valid_r;
  out_t out_data_r, skid_data_r;
  logic pop, push;

  assign pop       = out_valid_r && out_ready;
  assign push      = en && f_v_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (pop) begin
        skid_full_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_full_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= f_data_r;
      end else begin
        skid_data_r <= f_data_r;
      end
    end
  end

endmodule

[sv/dqsv_checker.sv]
module dqsv_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input dqsv_pkg::in_t                     in_data,
  input logic                              out_valid,
  input logic                              out_ready,
  input dqsv_pkg::out_t                    out_data,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [dqsv_pkg::VOLTAGE_BITS-1:0] cfg_data
);
  import dqsv_pkg::*;

  localparam logic [DUTY_W-1:0] HALF_DUTY = DUTY_W'(1) << (DUTY_FRAC_BITS - 1);
  localparam logic [DUTY_W-1:0] ONE_DUTY  = DUTY_W'(1) << DUTY_FRAC_BITS;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output valid or input stalled after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a bus fault shows the zero vector
  a_fault_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bus_fault |->
      out_data.duty_a == HALF_DUTY && out_data.duty_b == HALF_DUTY &&
      out_data.duty_c == HALF_DUTY)
    else $error("fault result without half duties");

  // duties stay within one
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.duty_a <= ONE_DUTY && out_data.duty_b <= ONE_DUTY &&
      out_data.duty_c <= ONE_DUTY)
    else $error("duty above one");

  // register writes are never held off
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind dq_to_svpwm_duty dqsv_checker u_dqsv_checker (.*);
